// ===== src/jitl_pkg.sv =====
`default_nettype none

package jitl_pkg;

    localparam int W         = 32;
    localparam int ACC_W     = 53;
    localparam int MAG_W     = 33;
    localparam int COEF_W    = 17;
    localparam int PROD_W    = MAG_W + COEF_W;
    localparam int NUM_W     = 52;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 160;
    localparam int IN_USER_W = 2;

    localparam int MIN_INTERVAL_US = 100;
    localparam int US_PER_S        = 1000000;
    localparam int WEIGHT_SHIFT    = 16;

    localparam logic [COEF_W-1:0] WEIGHT_ONE = COEF_W'(65536);
    localparam logic [COEF_W-1:0] ALPHA_NEW  = COEF_W'(64881);
    localparam logic [COEF_W-1:0] ALPHA_OLD  = COEF_W'(655);
    localparam logic [COEF_W-1:0] NUM_CO_HI  = COEF_W'(US_PER_S / 65536);
    localparam logic [COEF_W-1:0] NUM_CO_LO  = COEF_W'(US_PER_S % 65536);

    localparam logic [IN_USER_W-1:0] KIND_START  = 2'd0;
    localparam logic [IN_USER_W-1:0] KIND_TARGET = 2'd1;
    localparam logic [IN_USER_W-1:0] KIND_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORIOLIS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 3'd4;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [NUM_W-1:0]        t_num;

    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [COEF_W-1:0] coef;
        logic              neg;
    } t_mul_req;

    typedef struct packed {
        logic         start;
        t_num         num;
        logic [W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_num quot;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FILT_A,
        ST_FILT_B,
        ST_FILT_C,
        ST_FILT_D,
        ST_TERM_OP,
        ST_TERM_HI,
        ST_TERM_LO,
        ST_TERM_ADD,
        ST_TERM_ACC,
        ST_DELTA,
        ST_CLAMP,
        ST_RESULT,
        ST_NUM_HI,
        ST_NUM_LO,
        ST_NUM_ADD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SMOOTH_A,
        ST_SMOOTH_B,
        ST_SMOOTH_C,
        ST_SMOOTH_D,
        ST_SMOOTH_E
    } t_state;

endpackage

`default_nettype wire

// ===== src/jitl_mul.sv =====
`default_nettype none

module jitl_mul (
    input  logic               i_clk,
    input  jitl_pkg::t_mul_req i_req,
    output jitl_pkg::t_acc     o_prod
);
    import jitl_pkg::*;

    logic [PROD_W-1:0] prod_u;
    t_acc              prod_ext;
    t_acc              n_prod;
    t_acc              r_prod;

    assign prod_u   = i_req.mag * i_req.coef;
    assign prod_ext = {{(ACC_W - PROD_W){1'b0}}, prod_u};
    assign n_prod   = i_req.neg ? -prod_ext : prod_ext;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== src/jitl_div.sv =====
`default_nettype none

module jitl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jitl_pkg::t_div_req i_req,
    output jitl_pkg::t_div_rsp o_rsp
);
    import jitl_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem, n_rem;
    t_num             r_q, n_q;
    logic [W-1:0]     r_den, n_den;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_diff;
    logic             fits;

    assign rem_sh   = {r_rem, r_q[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign fits     = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = fits ? rem_diff[W-1:0] : rem_sh[W-1:0];
            n_q   = {r_q[NUM_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

// ===== src/joint_impedance_torque_law_core.sv =====
// A control tick goes from acceptance to a valid torque word through eight passes through
// the one shared 33x17 multiplier and the sum and limit steps after them.
// A new target whose interval is long enough spends most of its time in the
// bit-serial 52-bit divider; every other word leaves the core idle once it is accepted.
// Synchronous active-low reset restores the register defaults and clears all joint state.
`default_nettype none

module joint_impedance_torque_law_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [jitl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jitl_pkg::W-1:0]              i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // position, timestamp_us, measured_velocity, coriolis_torque, present_command
    input  logic [jitl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [jitl_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // torque_command
    output logic [jitl_pkg::W-1:0]              m_axis_tdata
);
    import jitl_pkg::*;

    localparam logic [1:0] TERM_CORIOLIS  = 2'd0;
    localparam logic [1:0] TERM_STIFFNESS = 2'd1;
    localparam logic [1:0] TERM_LAST      = 2'd2;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic signed [W-1:0] sat32(input t_acc x);
        t_acc hi_lim;
        t_acc lo_lim;
        hi_lim = t_acc'(32'sh7fff_ffff);
        lo_lim = -t_acc'(33'sh0_8000_0000);
        if (x > hi_lim) return 32'sh7fff_ffff;
        if (x < lo_lim) return 32'sh8000_0000;
        return x[W-1:0];
    endfunction

    function automatic t_acc shr_weight(input t_acc x);
        t_acc mag;
        mag = x[ACC_W-1] ? -x : x;
        mag = mag >>> WEIGHT_SHIFT;
        return x[ACC_W-1] ? -mag : mag;
    endfunction

    function automatic logic signed [W-1:0] sat_quot(input t_num q, input logic neg);
        if (!neg) begin
            if (q > NUM_W'(32'h7fff_ffff)) return 32'sh7fff_ffff;
            return q[W-1:0];
        end
        if (q > NUM_W'(33'h0_8000_0000)) return 32'sh8000_0000;
        return -q[W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [W-1:0]          r_stiff, n_stiff;
    logic [W-1:0]          r_damp, n_damp;
    logic [W-1:0]          r_cor_scale, n_cor_scale;
    logic [W-2:0]          r_step_lim, n_step_lim;
    logic [COEF_W-1:0]     r_smooth, n_smooth;

    logic signed [W-1:0]   r_target, n_target;
    logic signed [W-1:0]   r_prev_target, n_prev_target;
    logic signed [W-1:0]   r_est, n_est;
    logic [W-1:0]          r_prev_time, n_prev_time;
    logic                  r_have_prev, n_have_prev;
    logic signed [W-1:0]   r_fv, n_fv;

    logic [MAG_W-1:0]      r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic                  r_dneg, n_dneg;
    logic signed [W-1:0]   r_pos, n_pos;
    logic signed [W-1:0]   r_cor, n_cor;
    logic signed [W-1:0]   r_pres, n_pres;
    logic [W-1:0]          r_dt, n_dt;
    t_acc                  r_acc, n_acc;
    t_acc                  r_tau, n_tau;
    t_acc                  r_term, n_term;
    t_acc                  r_delta, n_delta;
    logic [1:0]            r_idx, n_idx;
    logic signed [W-1:0]   r_raw, n_raw;
    logic                  r_m_valid, n_m_valid;
    logic [W-1:0]          r_m_data, n_m_data;

    logic                  in_accept;
    logic signed [W-1:0]   in_pos;
    logic [W-1:0]          in_ts;
    logic signed [W-1:0]   in_vel;
    logic signed [W-1:0]   in_cor;
    logic signed [W-1:0]   in_pres;
    logic [W-1:0]          in_dt;
    logic                  long_gap;
    logic signed [MAG_W-1:0] in_diff;
    logic signed [MAG_W-1:0] term_op;
    logic [W-1:0]          gain;
    logic [COEF_W-1:0]     weight;
    t_acc                  step_lim;
    t_acc                  out_sum;
    logic                  out_free;

    t_mul_req              mul_req;
    t_acc                  mul_prod;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    jitl_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    jitl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_pos        = s_axis_tdata[31:0];
    assign in_ts         = s_axis_tdata[63:32];
    assign in_vel        = s_axis_tdata[95:64];
    assign in_cor        = s_axis_tdata[127:96];
    assign in_pres       = s_axis_tdata[159:128];
    assign in_dt         = in_ts - r_prev_time;
    assign long_gap      = in_dt > W'(MIN_INTERVAL_US);
    assign in_diff       = {in_pos[W-1], in_pos} - {r_prev_target[W-1], r_prev_target};
    assign weight        = (r_smooth > WEIGHT_ONE) ? WEIGHT_ONE : r_smooth;
    assign step_lim      = t_acc'({1'b0, r_step_lim});
    assign out_sum       = t_acc'(r_pres) + r_delta;
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        case (r_idx)
            TERM_CORIOLIS:  gain = r_cor_scale;
            TERM_STIFFNESS: gain = r_stiff;
            default:        gain = r_damp;
        endcase
    end

    always_comb begin
        case (r_idx)
            TERM_CORIOLIS:  term_op = {r_cor[W-1], r_cor};
            TERM_STIFFNESS: term_op = {r_target[W-1], r_target} - {r_pos[W-1], r_pos};
            default:        term_op = {r_est[W-1], r_est} - {r_fv[W-1], r_fv};
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_axis_tuser == KIND_TICK) begin
                        n_state = ST_FILT_A;
                    end else if (s_axis_tuser == KIND_TARGET && r_have_prev && long_gap) begin
                        n_state = ST_NUM_HI;
                    end
                end
            end
            ST_FILT_A:    n_state = ST_FILT_B;
            ST_FILT_B:    n_state = ST_FILT_C;
            ST_FILT_C:    n_state = ST_FILT_D;
            ST_FILT_D:    n_state = ST_TERM_OP;
            ST_TERM_OP:   n_state = ST_TERM_HI;
            ST_TERM_HI:   n_state = ST_TERM_LO;
            ST_TERM_LO:   n_state = ST_TERM_ADD;
            ST_TERM_ADD:  n_state = ST_TERM_ACC;
            ST_TERM_ACC:  n_state = (r_idx == TERM_LAST) ? ST_DELTA : ST_TERM_OP;
            ST_DELTA:     n_state = ST_CLAMP;
            ST_CLAMP:     n_state = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NUM_HI:    n_state = ST_NUM_LO;
            ST_NUM_LO:    n_state = ST_NUM_ADD;
            ST_NUM_ADD:   n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_SMOOTH_A;
                end
            end
            ST_SMOOTH_A:  n_state = ST_SMOOTH_B;
            ST_SMOOTH_B:  n_state = ST_SMOOTH_C;
            ST_SMOOTH_C:  n_state = ST_SMOOTH_D;
            ST_SMOOTH_D:  n_state = ST_SMOOTH_E;
            ST_SMOOTH_E:  n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_stiff       = r_stiff;
        n_damp        = r_damp;
        n_cor_scale   = r_cor_scale;
        n_step_lim    = r_step_lim;
        n_smooth      = r_smooth;
        n_target      = r_target;
        n_prev_target = r_prev_target;
        n_est         = r_est;
        n_prev_time   = r_prev_time;
        n_have_prev   = r_have_prev;
        n_fv          = r_fv;
        n_mag         = r_mag;
        n_neg         = r_neg;
        n_dneg        = r_dneg;
        n_pos         = r_pos;
        n_cor         = r_cor;
        n_pres        = r_pres;
        n_dt          = r_dt;
        n_acc         = r_acc;
        n_tau         = r_tau;
        n_term        = r_term;
        n_delta       = r_delta;
        n_idx         = r_idx;
        n_raw         = r_raw;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_data      = r_m_data;
        mul_req       = '0;
        div_req       = '0;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STIFFNESS: n_stiff     = i_cfg_data;
                CFG_DAMPING:   n_damp      = i_cfg_data;
                CFG_CORIOLIS:  n_cor_scale = i_cfg_data;
                CFG_STEP_LIM:  n_step_lim  = i_cfg_data[W-2:0];
                CFG_SMOOTHING: n_smooth    = i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (s_axis_tuser)
                        KIND_START: begin
                            n_target      = in_pos;
                            n_prev_target = in_pos;
                            n_est         = '0;
                            n_have_prev   = 1'b1;
                            n_prev_time   = in_ts;
                        end
                        KIND_TARGET: begin
                            if (!r_have_prev) begin
                                n_est       = '0;
                                n_have_prev = 1'b1;
                            end
                            n_target      = in_pos;
                            n_prev_target = in_pos;
                            n_prev_time   = in_ts;
                            n_mag         = abs_mag(in_diff);
                            n_dneg        = in_diff[MAG_W-1];
                            n_dt          = in_dt;
                        end
                        KIND_TICK: begin
                            n_mag  = abs_mag({in_vel[W-1], in_vel});
                            n_neg  = in_vel[W-1];
                            n_pos  = in_pos;
                            n_cor  = in_cor;
                            n_pres = in_pres;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILT_A: begin
                mul_req = '{mag: r_mag, coef: ALPHA_NEW, neg: r_neg};
                n_mag   = abs_mag({r_fv[W-1], r_fv});
                n_neg   = r_fv[W-1];
            end
            ST_FILT_B: begin
                mul_req = '{mag: r_mag, coef: ALPHA_OLD, neg: r_neg};
                n_acc   = mul_prod;
            end
            ST_FILT_C: begin
                n_acc = r_acc + mul_prod;
            end
            ST_FILT_D: begin
                n_fv  = sat32(shr_weight(r_acc));
                n_tau = '0;
                n_idx = TERM_CORIOLIS;
            end
            ST_TERM_OP: begin
                n_mag = abs_mag(term_op);
                n_neg = term_op[MAG_W-1];
            end
            ST_TERM_HI: begin
                mul_req = '{mag: r_mag, coef: {1'b0, gain[W-1:16]}, neg: 1'b0};
            end
            ST_TERM_LO: begin
                mul_req = '{mag: r_mag, coef: {1'b0, gain[15:0]}, neg: 1'b0};
                n_term  = mul_prod;
            end
            ST_TERM_ADD: begin
                n_term = r_term + (mul_prod >>> 16);
            end
            ST_TERM_ACC: begin
                n_tau = r_neg ? r_tau - r_term : r_tau + r_term;
                n_idx = r_idx + 2'd1;
            end
            ST_DELTA: begin
                n_delta = r_tau - t_acc'(r_pres);
            end
            ST_CLAMP: begin
                if (r_delta > step_lim) begin
                    n_delta = step_lim;
                end else if (r_delta < -step_lim) begin
                    n_delta = -step_lim;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = sat32(out_sum);
                end
            end
            ST_NUM_HI: begin
                mul_req = '{mag: r_mag, coef: NUM_CO_HI, neg: 1'b0};
            end
            ST_NUM_LO: begin
                mul_req = '{mag: r_mag, coef: NUM_CO_LO, neg: 1'b0};
                n_acc   = mul_prod <<< 16;
            end
            ST_NUM_ADD: begin
                n_acc = r_acc + mul_prod;
            end
            ST_DIV_START: begin
                div_req = '{start: 1'b1, num: r_acc[NUM_W-1:0], den: r_dt};
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_raw = sat_quot(div_rsp.quot, r_dneg);
                end
            end
            ST_SMOOTH_A: begin
                n_mag = abs_mag({r_raw[W-1], r_raw});
                n_neg = r_raw[W-1];
            end
            ST_SMOOTH_B: begin
                mul_req = '{mag: r_mag, coef: weight, neg: r_neg};
                n_mag   = abs_mag({r_est[W-1], r_est});
                n_neg   = r_est[W-1];
            end
            ST_SMOOTH_C: begin
                mul_req = '{mag: r_mag, coef: WEIGHT_ONE - weight, neg: r_neg};
                n_acc   = mul_prod;
            end
            ST_SMOOTH_D: begin
                n_acc = r_acc + mul_prod;
            end
            ST_SMOOTH_E: begin
                n_est = sat32(shr_weight(r_acc));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_stiff       <= '0;
            r_damp        <= '0;
            r_cor_scale   <= W'(65536);
            r_step_lim    <= (W-1)'(65536);
            r_smooth      <= COEF_W'(6554);
            r_target      <= '0;
            r_prev_target <= '0;
            r_est         <= '0;
            r_prev_time   <= '0;
            r_have_prev   <= 1'b0;
            r_fv          <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_stiff       <= n_stiff;
            r_damp        <= n_damp;
            r_cor_scale   <= n_cor_scale;
            r_step_lim    <= n_step_lim;
            r_smooth      <= n_smooth;
            r_target      <= n_target;
            r_prev_target <= n_prev_target;
            r_est         <= n_est;
            r_prev_time   <= n_prev_time;
            r_have_prev   <= n_have_prev;
            r_fv          <= n_fv;
            r_m_valid     <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_dneg   <= n_dneg;
        r_pos    <= n_pos;
        r_cor    <= n_cor;
        r_pres   <= n_pres;
        r_dt     <= n_dt;
        r_acc    <= n_acc;
        r_tau    <= n_tau;
        r_term   <= n_term;
        r_delta  <= n_delta;
        r_idx    <= n_idx;
        r_raw    <= n_raw;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ===== sim/tb_joint_impedance_torque_law_core.sv =====
module tb_joint_impedance_torque_law_core;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint VEL_WEIGHT_NEW = 64881;
    localparam longint VEL_WEIGHT_OLD = 655;
    localparam longint WEIGHT_FULL = 65536;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] pos;
        logic [31:0]        stamp;
        logic signed [31:0] vel;
        logic signed [31:0] cor;
        logic signed [31:0] present;
    } joint_word_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;

    joint_impedance_torque_law_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Gain registers as the block should hold them.
    logic [31:0] stiff_gain = 32'd0;
    logic [31:0] damp_gain = 32'd0;
    logic [31:0] cor_scale = 32'd65536;
    logic [30:0] step_limit = 31'd65536;
    logic [16:0] tv_smoothing = 17'd6554;

    // Joint state.
    logic signed [31:0] tgt_pos = '0;
    logic signed [31:0] prev_tgt = '0;
    logic signed [31:0] tgt_vel_est = '0;
    logic [31:0]        prev_tgt_time = '0;
    logic               have_prev_tgt = 1'b0;
    logic signed [31:0] vel_filt = '0;

    joint_word_t pending_words[$];
    logic [31:0] torque_expected[$];
    joint_word_t cur_word;

    int words_pushed = 0;
    int words_taken = 0;
    int send_gap = 0;
    int stall_left = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int mismatches = 0;
    int torques_checked = 0;
    int starts_seen = 0;
    int targets_seen = 0;
    int ticks_seen = 0;
    int unused_seen = 0;
    int gain_sets = 0;
    logic [31:0] stamp_now = '0;

    function automatic logic [31:0] sat_word(longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic longint shift_toward_zero(longint x, int s);
        if (x >= 0) return x >>> s;
        return -((-x) >>> s);
    endfunction

    // Unsigned Q16.16 gain times a signed value, truncated toward zero.
    function automatic longint scale_by_gain(logic [31:0] g, longint b);
        logic [63:0] mag;
        logic [95:0] prod;
        longint r;
        mag = (b < 0) ? 64'(-b) : 64'(b);
        prod = {32'd0, mag} * {64'd0, g};
        r = longint'(prod[79:16]);
        return (b < 0) ? -r : r;
    endfunction

    task automatic predict_torque(joint_word_t w);
        logic [31:0] dt;
        longint diff, raw, wt, acc, tau, delta, lim;
        case (w.kind)
            jitl_pkg::KIND_START: begin
                starts_seen++;
                tgt_pos = w.pos;
                prev_tgt = w.pos;
                tgt_vel_est = '0;
                have_prev_tgt = 1'b1;
                prev_tgt_time = w.stamp;
            end
            jitl_pkg::KIND_TARGET: begin
                targets_seen++;
                if (have_prev_tgt) begin
                    dt = w.stamp - prev_tgt_time;
                    if (dt > jitl_pkg::MIN_INTERVAL_US) begin
                        diff = longint'(w.pos) - longint'(prev_tgt);
                        raw = longint'($signed(sat_word((diff * jitl_pkg::US_PER_S)
                                                        / longint'(dt))));
                        wt = (tv_smoothing > 17'd65536) ? WEIGHT_FULL : longint'(tv_smoothing);
                        acc = wt * raw + (WEIGHT_FULL - wt) * longint'(tgt_vel_est);
                        tgt_vel_est = sat_word(shift_toward_zero(acc, 16));
                    end
                end else begin
                    tgt_vel_est = '0;
                    have_prev_tgt = 1'b1;
                end
                tgt_pos = w.pos;
                prev_tgt = w.pos;
                prev_tgt_time = w.stamp;
            end
            jitl_pkg::KIND_TICK: begin
                ticks_seen++;
                acc = VEL_WEIGHT_NEW * longint'(w.vel) + VEL_WEIGHT_OLD * longint'(vel_filt);
                vel_filt = sat_word(shift_toward_zero(acc, 16));
                tau = scale_by_gain(cor_scale, longint'(w.cor))
                    + scale_by_gain(stiff_gain, longint'(tgt_pos) - longint'(w.pos))
                    + scale_by_gain(damp_gain, longint'(tgt_vel_est) - longint'(vel_filt));
                lim = longint'(step_limit);
                delta = tau - longint'(w.present);
                if (delta > lim) delta = lim;
                if (delta < -lim) delta = -lim;
                torque_expected = {torque_expected, sat_word(longint'(w.present) + delta)};
            end
            default: unused_seen++;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 30) $display("MISMATCH %s: got %h, want %h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_torque(cur_word);
                words_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0 && send_idle_pct != 0 &&
                             $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 17);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    s_axis_tdata <= {cur_word.present, cur_word.cor, cur_word.vel,
                                     cur_word.stamp, cur_word.pos};
                    s_axis_tuser <= cur_word.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (torque_expected.size() == 0) begin
                    report_mismatch("torque word with nothing expected", m_axis_tdata, '0);
                end else begin
                    torques_checked++;
                    if (m_axis_tdata !== torque_expected[0])
                        report_mismatch("torque_command", m_axis_tdata, torque_expected[0]);
                    void'(torque_expected.pop_front());
                end
            end
            if (holds_done != holds_asked) begin
                holds_done++;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_word(logic [1:0] kind, logic [31:0] pos, logic [31:0] stamp,
                            logic [31:0] vel, logic [31:0] cor, logic [31:0] present);
        joint_word_t w;
        w.kind = kind;
        w.pos = pos;
        w.stamp = stamp;
        w.vel = vel;
        w.cor = cor;
        w.present = present;
        pending_words = {pending_words, w};
        words_pushed++;
    endtask

    task automatic wait_drained();
        while (words_taken != words_pushed || torque_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            jitl_pkg::CFG_STIFFNESS: stiff_gain = val;
            jitl_pkg::CFG_DAMPING:   damp_gain = val;
            jitl_pkg::CFG_CORIOLIS:  cor_scale = val;
            jitl_pkg::CFG_STEP_LIM:  step_limit = val[30:0];
            jitl_pkg::CFG_SMOOTHING: tv_smoothing = val[16:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_gains(logic [31:0] s, logic [31:0] d, logic [31:0] c,
                               logic [31:0] l, logic [31:0] w);
        write_reg(jitl_pkg::CFG_STIFFNESS, s);
        write_reg(jitl_pkg::CFG_DAMPING, d);
        write_reg(jitl_pkg::CFG_CORIOLIS, c);
        write_reg(jitl_pkg::CFG_STEP_LIM, l);
        write_reg(jitl_pkg::CFG_SMOOTHING, w);
        gain_sets++;
    endtask

    // Mostly values of a plausible size, sometimes anything, sometimes an extreme.
    function automatic logic [31:0] pick_value(int span_bits);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return $urandom();
        if (r == 1) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return 32'($signed($urandom()) >>> (32 - span_bits));
    endfunction

    function automatic logic [31:0] pick_gain(logic [31:0] top, logic [31:0] usual);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return top;
        return $urandom_range(0, usual);
    endfunction

    task automatic gen_motion(int count);
        int unsigned r;
        int unsigned q;
        add_word(jitl_pkg::KIND_START, pick_value(18), stamp_now, $urandom(), $urandom(),
                 $urandom());
        for (int i = 1; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                stamp_now += $urandom_range(0, 100000);
                add_word(jitl_pkg::KIND_START, pick_value(18), stamp_now, $urandom(),
                         $urandom(), $urandom());
            end else if (r < 28) begin
                q = $urandom_range(0, 19);
                if (q == 0) stamp_now += $urandom_range(0, 100);
                else if (q == 1) stamp_now += $urandom();
                else stamp_now += $urandom_range(101, 20000);
                add_word(jitl_pkg::KIND_TARGET, pick_value(18), stamp_now, $urandom(),
                         $urandom(), $urandom());
            end else if (r < 31) begin
                add_word(KIND_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom());
            end else begin
                add_word(jitl_pkg::KIND_TICK, pick_value(18), $urandom(), pick_value(18),
                         pick_value(20), pick_value(22));
            end
        end
    endtask

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: a target before any start, extremes, interval edges and wrap.
        add_word(jitl_pkg::KIND_TARGET, 32'h0003_0000, 32'h0000_1000, 0, 0, 0);
        add_word(jitl_pkg::KIND_TICK, 32'h0000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
        add_word(jitl_pkg::KIND_TICK, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
        add_word(KIND_UNUSED, '1, '1, '1, '1, '1);
        add_word(jitl_pkg::KIND_START, 32'h8000_0000, 32'hFFFF_FF00, 0, 0, 0);
        add_word(jitl_pkg::KIND_TARGET, 32'h7FFF_FFFF, 32'h0000_0010, 0, 0, 0);
        add_word(jitl_pkg::KIND_TARGET, 32'h0000_0000, 32'h0000_0074, 0, 0, 0);
        add_word(jitl_pkg::KIND_TARGET, 32'h0000_1000, 32'h0000_00A6, 0, 0, 0);
        add_word(jitl_pkg::KIND_TARGET, 32'h0000_2000, 32'h0000_010B, 0, 0, 0);
        add_word(jitl_pkg::KIND_TICK, 32'h0000_1000, 0, 0, 0, 0);
        add_word(jitl_pkg::KIND_TICK, 32'h0000_0000, 0, 32'h0001_0000, 32'hFFFF_0000,
                 32'hFFFF_FFFF);
        add_word(jitl_pkg::KIND_START, 32'h0000_0000, 32'h0000_0000, 0, 0, 0);
        wait_drained();

        // Every gain at its top, smoothing above one.
        apply_gains('1, '1, '1, 32'h7FFF_FFFF, 32'h0001_FFFF);
        add_word(jitl_pkg::KIND_TARGET, 32'h8000_0000, 32'h0000_0200, 0, 0, 0);
        add_word(jitl_pkg::KIND_TICK, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        add_word(jitl_pkg::KIND_TICK, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF);
        add_word(jitl_pkg::KIND_TICK, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
        add_word(jitl_pkg::KIND_TARGET, 32'h7FFF_FFFF, 32'h0000_0400, 0, 0, 0);
        add_word(jitl_pkg::KIND_TICK, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
        wait_drained();

        // Every gain at zero: the command may not move at all.
        apply_gains('0, '0, '0, '0, '0);
        add_word(jitl_pkg::KIND_TICK, 32'h0001_2345, 0, 32'h0000_4000, 32'h0100_0000,
                 32'h00AB_CDEF);
        add_word(jitl_pkg::KIND_TARGET, 32'h0005_0000, 32'h0000_1000, 0, 0, 0);
        add_word(jitl_pkg::KIND_TICK, 32'hFFF0_0000, 0, 32'hFFFF_0000, 32'h0000_8000,
                 32'h8000_0000);
        add_word(KIND_UNUSED, '0, '0, '0, '0, '0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            apply_gains(pick_gain('1, 32'h0100_0000), pick_gain('1, 32'h0020_0000),
                        pick_gain('1, 32'h0004_0000), pick_gain(32'h7FFF_FFFF, 32'h0010_0000),
                        pick_gain(32'h0001_FFFF, 32'h0001_0000));
            case (p % 4)
                0: begin send_idle_pct = 10; recv_idle_pct = 10; end
                1: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                2: begin send_idle_pct = 30; recv_idle_pct = 5;  end
                default: begin send_idle_pct = 5; recv_idle_pct = 30; end
            endcase
            if (p == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 2) holds_asked++;
            if (p == 4) begin
                gen_motion(55);
                wait_drained();
                gen_motion(60);
            end else begin
                gen_motion(115);
            end
            wait_drained();
        end

        $display("Covered %0d words (%0d starts, %0d targets, %0d ticks, %0d unused kind)",
                 words_taken, starts_seen, targets_seen, ticks_seen, unused_seen);
        $display("under %0d gain settings; %0d torque words compared, %0d mismatches.",
                 gain_sets, torques_checked, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
